// ===== rtl/mqttp_pkg.sv =====
`timescale 1ns / 1ps

package mqttp_pkg;

    localparam int unsigned LENGTH_GROUPS_DEFAULT = 4;
    localparam int unsigned GROUP_W = 3;
    localparam int unsigned LENGTH_W = 28;
    localparam int unsigned TOPIC_W = 16;

    localparam logic [LENGTH_W-1:0] BODY_MAX = 28'hFFF_FFFF;

    localparam logic [3:0] PKT_CONNACK = 4'd2;
    localparam logic [3:0] PKT_PUBLISH = 4'd3;
    localparam logic [3:0] PKT_PINGRESP = 4'd13;

    typedef enum logic [1:0]
    {
        PH_HEADER = 2'd0,
        PH_LENGTH = 2'd1,
        PH_BODY = 2'd2
    } phase_t;

    typedef enum logic [2:0]
    {
        ROLE_HEADER = 3'd0,
        ROLE_LENGTH = 3'd1,
        ROLE_TOPIC_LENGTH = 3'd2,
        ROLE_TOPIC = 3'd3,
        ROLE_PACKET_ID = 3'd4,
        ROLE_PAYLOAD = 3'd5,
        ROLE_IGNORED = 3'd6
    } role_t;

    typedef enum logic [2:0]
    {
        V_OTHER = 3'd0,
        V_PUBLISH_OK = 3'd1,
        V_CONNACK_ACCEPTED = 3'd2,
        V_CONNACK_REFUSED = 3'd3,
        V_PINGRESP = 3'd4,
        V_MALFORMED = 3'd5
    } verdict_t;

    typedef struct packed
    {
        logic [7:0] data_byte;
        logic last_byte;
    } item_t;

    typedef struct packed
    {
        logic [7:0] out_byte;
        role_t byte_role;
        logic final_res;
        verdict_t verdict;
        logic [3:0] packet_type;
        logic [TOPIC_W-1:0] topic_length;
    } result_t;

endpackage

// ===== rtl/mqtt_packet_parser.sv =====
`timescale 1ns / 1ps
// A byte passes from the input register through the parse logic into the
// output register, where its result is held until its transfer.
// Throughput: one byte per cycle while result_stall does not hold the output
// register; a stalled output also stalls the input.
// Reset clears both valid flags and returns the parser to the header byte;
// after the final byte of a message the parser returns there as well.

module mqtt_packet_parser #(
    parameter int unsigned LENGTH_GROUPS = mqttp_pkg::LENGTH_GROUPS_DEFAULT
) (
    input  logic clk,
    input  logic rst_n,
    input  logic item_valid,
    output logic item_stall,
    input  mqttp_pkg::item_t item,
    output logic result_valid,
    input  logic result_stall,
    output mqttp_pkg::result_t result
);
    import mqttp_pkg::*;

    logic held_valid_reg;
    item_t held_reg;
    logic result_valid_reg;
    result_t result_reg;
    result_t parsed;
    logic out_free;
    logic advance;

    assign out_free = !result_valid_reg || !result_stall;
    assign advance = held_valid_reg && out_free;
    assign item_stall = held_valid_reg && !out_free;
    assign result_valid = result_valid_reg;
    assign result = result_reg;

    mqttp_core #(
        .LENGTH_GROUPS(LENGTH_GROUPS)
    ) u_core (
        .clk(clk),
        .rst_n(rst_n),
        .step(advance),
        .item(held_reg),
        .result(parsed)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_valid_reg <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (!item_stall)
                held_valid_reg <= item_valid;
            if (out_free)
                result_valid_reg <= advance;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && !item_stall)
            held_reg <= item;
        if (advance)
            result_reg <= parsed;
    end

    a_verdict_only_final: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.final_res |-> result.verdict == V_OTHER)
        else $error("verdict set on a byte that is not final");

    a_header_type: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.byte_role == ROLE_HEADER
        |-> result.packet_type == result.out_byte[7:4])
        else $error("packet type differs from the header byte");

    a_topic_publish: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.topic_length != '0 |-> result.packet_type == PKT_PUBLISH)
        else $error("topic length reported for a packet that is not a publish");

    a_stall_needs_held: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> held_valid_reg && result_valid_reg)
        else $error("input stalled while the pipeline has room");

endmodule

// ===== rtl/mqttp_core.sv =====
`timescale 1ns / 1ps

module mqttp_core #(
    parameter int unsigned LENGTH_GROUPS = mqttp_pkg::LENGTH_GROUPS_DEFAULT
) (
    input  logic clk,
    input  logic rst_n,
    input  logic step,
    input  mqttp_pkg::item_t item,
    output mqttp_pkg::result_t result
);
    import mqttp_pkg::*;

    phase_t phase_reg, phase_next;
    logic [3:0] type_reg, type_next;
    logic [1:0] qos_reg, qos_next;
    logic [LENGTH_W-1:0] length_reg, length_next;
    logic [GROUP_W-1:0] groups_reg, groups_next;
    logic [LENGTH_W-1:0] body_reg, body_next;
    logic [TOPIC_W-1:0] topic_reg, topic_next;
    logic [7:0] rc_reg, rc_next;
    logic fault_reg, fault_next;

    logic [7:0] b;
    logic [LENGTH_W-1:0] group_val;
    logic [LENGTH_W-1:0] topic_end;
    logic [LENGTH_W-1:0] id_end;
    logic [LENGTH_W-1:0] need;
    logic len_ok;
    role_t role;
    verdict_t verdict;

    assign b = item.data_byte;
    assign topic_end = LENGTH_W'(topic_reg) + LENGTH_W'(2);
    assign id_end = LENGTH_W'(topic_reg) + LENGTH_W'(4);

    always_comb
    begin
        unique case (groups_reg[1:0])
            2'd0: group_val = {21'd0, b[6:0]};
            2'd1: group_val = {14'd0, b[6:0], 7'd0};
            2'd2: group_val = {7'd0, b[6:0], 14'd0};
            2'd3: group_val = {b[6:0], 21'd0};
            default: group_val = '0;
        endcase
    end

    always_comb
    begin
        phase_next = phase_reg;
        type_next = type_reg;
        qos_next = qos_reg;
        length_next = length_reg;
        groups_next = groups_reg;
        body_next = body_reg;
        topic_next = topic_reg;
        rc_next = rc_reg;
        fault_next = fault_reg;
        role = ROLE_IGNORED;

        unique case (phase_reg)
            PH_HEADER:
            begin
                role = ROLE_HEADER;
                type_next = b[7:4];
                qos_next = b[2:1];
                length_next = '0;
                groups_next = '0;
                body_next = '0;
                topic_next = '0;
                rc_next = '0;
                fault_next = 1'b0;
                phase_next = PH_LENGTH;
            end
            PH_LENGTH:
            begin
                role = ROLE_LENGTH;
                length_next = length_reg | group_val;
                groups_next = groups_reg + GROUP_W'(1);
                if (!b[7])
                begin
                    phase_next = PH_BODY;
                end
                else if (groups_next >= GROUP_W'(LENGTH_GROUPS))
                begin
                    fault_next = 1'b1;
                    phase_next = PH_BODY;
                end
            end
            PH_BODY:
            begin
                priority if (fault_reg || type_reg != PKT_PUBLISH || body_reg >= length_reg)
                    role = ROLE_IGNORED;
                else if (body_reg < LENGTH_W'(2))
                    role = ROLE_TOPIC_LENGTH;
                else if (body_reg < topic_end)
                    role = ROLE_TOPIC;
                else if (qos_reg != 2'd0 && body_reg < id_end)
                    role = ROLE_PACKET_ID;
                else
                    role = ROLE_PAYLOAD;

                if (!fault_reg)
                begin
                    if (type_reg == PKT_PUBLISH && body_reg == LENGTH_W'(0))
                        topic_next = {b, 8'd0};
                    else if (type_reg == PKT_PUBLISH && body_reg == LENGTH_W'(1))
                        topic_next = topic_reg | {8'd0, b};
                    else if (type_reg == PKT_CONNACK && body_reg == LENGTH_W'(1))
                        rc_next = b;
                end
                if (body_reg < BODY_MAX)
                    body_next = body_reg + LENGTH_W'(1);
            end
            default:
            begin
                phase_next = PH_HEADER;
            end
        endcase

        len_ok = (phase_next == PH_BODY) && !fault_next;
        need = LENGTH_W'(topic_next) + LENGTH_W'(2) + ((qos_next != 2'd0) ? LENGTH_W'(2) : '0);

        unique case (type_next)
            PKT_PUBLISH:
                verdict = (len_ok && body_next >= length_next && length_next >= need)
                          ? V_PUBLISH_OK : V_MALFORMED;
            PKT_CONNACK:
            begin
                if (len_ok && length_next >= LENGTH_W'(2) && body_next >= LENGTH_W'(2))
                    verdict = (rc_next == 8'd0) ? V_CONNACK_ACCEPTED : V_CONNACK_REFUSED;
                else
                    verdict = V_MALFORMED;
            end
            PKT_PINGRESP:
                verdict = (len_ok && length_next == '0) ? V_PINGRESP : V_MALFORMED;
            default:
                verdict = V_OTHER;
        endcase

        result.out_byte = b;
        result.byte_role = role;
        result.final_res = item.last_byte;
        result.verdict = item.last_byte ? verdict : V_OTHER;
        result.packet_type = type_next;
        result.topic_length = (type_next == PKT_PUBLISH) ? topic_next : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEADER;
            type_reg <= '0;
            qos_reg <= '0;
            length_reg <= '0;
            groups_reg <= '0;
            body_reg <= '0;
            topic_reg <= '0;
            rc_reg <= '0;
            fault_reg <= 1'b0;
        end
        else if (step)
        begin
            if (item.last_byte)
            begin
                phase_reg <= PH_HEADER;
                type_reg <= '0;
                qos_reg <= '0;
                length_reg <= '0;
                groups_reg <= '0;
                body_reg <= '0;
                topic_reg <= '0;
                rc_reg <= '0;
                fault_reg <= 1'b0;
            end
            else
            begin
                phase_reg <= phase_next;
                type_reg <= type_next;
                qos_reg <= qos_next;
                length_reg <= length_next;
                groups_reg <= groups_next;
                body_reg <= body_next;
                topic_reg <= topic_next;
                rc_reg <= rc_next;
                fault_reg <= fault_next;
            end
        end
    end

endmodule
